// ----- src/ssse3_pkg.sv -----
// Package for the SSSE3 lane ALU: command codes, payload structs, lane constants and a saturation function.
// No dependencies.
`timescale 1ns / 1ps
package ssse3_pkg;

  localparam logic [3:0] CMD_SHUFB    = 4'd0;
  localparam logic [3:0] CMD_HADDW    = 4'd1;
  localparam logic [3:0] CMD_HADDD    = 4'd2;
  localparam logic [3:0] CMD_HADDSW   = 4'd3;
  localparam logic [3:0] CMD_MADDUBSW = 4'd4;
  localparam logic [3:0] CMD_HSUBW    = 4'd5;
  localparam logic [3:0] CMD_HSUBD    = 4'd6;
  localparam logic [3:0] CMD_HSUBSW   = 4'd7;
  localparam logic [3:0] CMD_SIGNB    = 4'd8;
  localparam logic [3:0] CMD_SIGNW    = 4'd9;
  localparam logic [3:0] CMD_SIGND    = 4'd10;
  localparam logic [3:0] CMD_MULHRSW  = 4'd11;
  localparam logic [3:0] CMD_ABSB     = 4'd12;
  localparam logic [3:0] CMD_ABSW     = 4'd13;
  localparam logic [3:0] CMD_ABSD     = 4'd14;
  localparam logic [3:0] CMD_ALIGNR   = 4'd15;

  localparam int NUM_LANES = 8;
  localparam logic signed [31:0] RND_CONST = 32'sh4000;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [63:0] first_lo;
    logic [63:0] first_hi;
    logic [63:0] second_lo;
    logic [63:0] second_hi;
    logic [7:0]  shift_bytes;
  } in_t;

  typedef struct packed {
    logic [63:0] result_lo;
    logic [63:0] result_hi;
  } out_t;

  function automatic logic [15:0] sat16(input logic signed [17:0] x);
    if (x > 18'sd32767) return 16'h7fff;
    if (x < -18'sd32768) return 16'h8000;
    return x[15:0];
  endfunction

endpackage

// ----- src/ssse3_integer_simd_lane_alu.sv -----
// Top level of the SSSE3 lane ALU: lanes, pair units, shuffle/align and output merge.
// Depends on ssse3_pkg, ssse3_lane and ssse3_pair.
`timescale 1ns / 1ps
// Usage: one transaction on the input channel (in_valid/in_ready, payload in_data)
// carries a command, two 128-bit source lanes and a byte immediate. Exactly one
// transaction leaves on the output channel (out_valid/out_ready, payload out_data)
// for each one accepted, in order.
// Four 32-bit lane slices compute the elementwise operations side by side, eight
// pair units form the horizontal and multiply-add results, and a merging stage
// selects by command and places the pair results into the result lane.
// The result sits in the output register on the cycle after acceptance.
// Throughput is one transaction per cycle while out_ready stays high, set by the single output
// register, which reloads in the same cycle it is drained.
// When the receiver stalls, the output register holds its transaction and in_ready
// falls, so nothing is lost; the input is taken again once out_ready returns.
// Reset clears the output valid flag; the output data register is not reset.
module ssse3_integer_simd_lane_alu (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ssse3_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ssse3_pkg::out_t out_data
);
  import ssse3_pkg::*;

  logic [127:0] f, s, r_next, lane_y, cat_sh;
  logic [255:0] cat;
  logic [NUM_LANES-1:0][31:0] pair_y;
  logic [3:0]   cmd;
  logic         is_dword;
  logic         out_valid_next;
  out_t         out_reg;

  assign cmd = in_data.cmd;
  assign f = {in_data.first_hi, in_data.first_lo};
  assign s = {in_data.second_hi, in_data.second_lo};
  assign is_dword = (cmd == CMD_HADDD) || (cmd == CMD_HSUBD);

  // Elementwise lanes, one per dword slice.
  for (genvar g = 0; g < 4; g++) begin : g_lane
    ssse3_lane u_lane (
      .cmd(cmd), .a(f[32*g +: 32]), .b(s[32*g +: 32]), .y(lane_y[32*g +: 32])
    );
  end

  // Pair units: units 0..3 read the first source, 4..7 the second. For the dword
  // forms, only units 0,1 and 4,5 carry results (two dwords per source).
  // For multiply-add, unit g takes word g of both sources.
  for (genvar g = 0; g < NUM_LANES; g++) begin : g_pair
    logic [127:0] src;
    logic [31:0]  pa, pb;
    logic [15:0]  pm;
    assign src = (g < 4) ? f : s;
    assign pa = (cmd == CMD_MADDUBSW) ? {16'd0, f[16*g +: 16]} :
                is_dword ? src[64*(g % 2) +: 32] : src[32*(g % 4) +: 32];
    assign pb = src[64*(g % 2) + 32 +: 32];
    assign pm = s[16*g +: 16];
    ssse3_pair u_pair (
      .cmd(cmd), .a(pa), .b(pb), .m(pm), .y(pair_y[g])
    );
  end

  always_comb begin
    cat = {f, s};
    cat_sh = 128'((cat >> {in_data.shift_bytes[4:0], 3'b000}));
    r_next = 128'd0;
    case (cmd) inside
      CMD_SHUFB: begin
        for (int i = 0; i < 16; i++) begin
          r_next[8*i +: 8] = s[8*i+7] ? 8'd0 : f[8*s[8*i +: 4] +: 8];
        end
      end
      CMD_HADDD, CMD_HSUBD: begin
        r_next = {pair_y[5], pair_y[4], pair_y[1], pair_y[0]};
      end
      CMD_HADDW, CMD_HSUBW, CMD_HADDSW, CMD_HSUBSW, CMD_MADDUBSW: begin
        for (int i = 0; i < NUM_LANES; i++) begin
          r_next[16*i +: 16] = pair_y[i][15:0];
        end
      end
      CMD_ALIGNR: r_next = (in_data.shift_bytes >= 8'd32) ? 128'd0 : cat_sh;
      default: r_next = lane_y;
    endcase
  end

  assign in_ready = !out_valid || out_ready;
  assign out_valid_next = (in_valid && in_ready) || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
    if (in_valid && in_ready) begin
      out_reg <= {r_next[63:0], r_next[127:64]};
    end
  end

  assign out_data = out_reg;

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");
  a_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted transaction lost");
`endif

endmodule

// ----- src/ssse3_lane.sv -----
// One 32-bit lane slice: sign, abs and rounded high multiply on the slice's elements.
// Depends on ssse3_pkg.
`timescale 1ns / 1ps
module ssse3_lane (
  input  logic [3:0]  cmd,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  import ssse3_pkg::*;

  logic signed [31:0] p0, p1;
  logic [31:0] t0, t1;
  logic [31:0] nega, negb;

  always_comb begin
    p0 = $signed(a[15:0]) * $signed(b[15:0]);
    p1 = $signed(a[31:16]) * $signed(b[31:16]);
    t0 = 32'(p0 + RND_CONST);
    t1 = 32'(p1 + RND_CONST);
    nega = 32'd0 - a;
    negb = 32'd0 - b;
    y = 32'd0;
    case (cmd)
      CMD_SIGNB: begin
        for (int k = 0; k < 4; k++) begin
          y[8*k +: 8] = b[8*k+7] ? 8'(8'd0 - a[8*k +: 8]) :
                        (b[8*k +: 8] == 8'd0) ? 8'd0 : a[8*k +: 8];
        end
      end
      CMD_SIGNW: begin
        for (int k = 0; k < 2; k++) begin
          y[16*k +: 16] = b[16*k+15] ? 16'(16'd0 - a[16*k +: 16]) :
                          (b[16*k +: 16] == 16'd0) ? 16'd0 : a[16*k +: 16];
        end
      end
      CMD_SIGND: y = b[31] ? nega : (b == 32'd0) ? 32'd0 : a;
      CMD_ABSB: begin
        for (int k = 0; k < 4; k++) begin
          y[8*k +: 8] = b[8*k+7] ? 8'(8'd0 - b[8*k +: 8]) : b[8*k +: 8];
        end
      end
      CMD_ABSW: begin
        for (int k = 0; k < 2; k++) begin
          y[16*k +: 16] = b[16*k+15] ? 16'(16'd0 - b[16*k +: 16]) : b[16*k +: 16];
        end
      end
      CMD_ABSD: y = b[31] ? negb : b;
      CMD_MULHRSW: y = {t1[30:15], t0[30:15]};
      default: y = 32'd0;
    endcase
  end

endmodule

// ----- src/ssse3_pair.sv -----
// Pair unit: horizontal add/subtract and multiply-add on its slice inputs a, b and m.
// Depends on ssse3_pkg.
`timescale 1ns / 1ps
module ssse3_pair (
  input  logic [3:0]  cmd,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [15:0] m,
  output logic [31:0] y
);
  import ssse3_pkg::*;

  logic signed [17:0] sw, dw, p0, p1;

  always_comb begin
    sw = 18'($signed(a[15:0])) + 18'($signed(a[31:16]));
    dw = 18'($signed(a[15:0])) - 18'($signed(a[31:16]));
    p0 = 18'($signed({1'b0, a[7:0]}) * $signed(m[7:0]));
    p1 = 18'($signed({1'b0, a[15:8]}) * $signed(m[15:8]));
    y = 32'd0;
    case (cmd)
      CMD_HADDW:  y[15:0] = sw[15:0];
      CMD_HSUBW:  y[15:0] = dw[15:0];
      CMD_HADDSW: y[15:0] = sat16(sw);
      CMD_HSUBSW: y[15:0] = sat16(dw);
      CMD_HADDD:  y = a + b;
      CMD_HSUBD:  y = a - b;
      CMD_MADDUBSW: y[15:0] = sat16(p0 + p1);
      default: y = 32'd0;
    endcase
  end

endmodule

// ----- verif/ssse3_integer_simd_lane_alu_test.sv -----
// Self-checking bench for the SSSE3 lane ALU: directed and random commands,
// predicted in the bench and compared per output transaction.
// Depends on ssse3_pkg and ssse3_integer_simd_lane_alu.
`timescale 1ns / 1ps
module ssse3_integer_simd_lane_alu_test;
  import ssse3_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  ssse3_integer_simd_lane_alu u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  out_t lane_results_due[$];
  int   mismatch_count;
  int   cycle_count;
  bit   sink_busy;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Saturate a full-precision sum to a signed word.
  function automatic logic [15:0] clamp_word(input int x);
    if (x > 32767) return 16'h7fff;
    if (x < -32768) return 16'h8000;
    return x[15:0];
  endfunction

  // Expected result lane for one command; bytes are indexed little-endian.
  function automatic out_t lane_op(input in_t t);
    logic [127:0] f, s, r;
    logic [255:0] cat;
    int i, a, b, half, n, w, v;
    logic [31:0] ua, ub, uv;
    out_t o;
    f = {t.first_hi, t.first_lo};
    s = {t.second_hi, t.second_lo};
    r = '0;
    case (t.cmd) inside
      CMD_SHUFB: begin
        for (i = 0; i < 16; i++)
          r[8*i +: 8] = s[8*i+7] ? 8'h00 : f[8*s[8*i +: 4] +: 8];
      end
      CMD_HADDW, CMD_HADDD, CMD_HADDSW, CMD_HSUBW, CMD_HSUBD, CMD_HSUBSW: begin
        n = (t.cmd == CMD_HADDD || t.cmd == CMD_HSUBD) ? 4 : 2;
        w = 8 * n;
        half = 8 / n;
        for (i = 0; i < 2 * half; i++) begin
          if (i < half) begin
            ua = 32'(f >> (w*(2*i))); ub = 32'(f >> (w*(2*i+1)));
          end else begin
            ua = 32'(s >> (w*(2*(i-half)))); ub = 32'(s >> (w*(2*(i-half)+1)));
          end
          if (n == 4) begin
            uv = (t.cmd == CMD_HSUBD) ? ua - ub : ua + ub;
            r[32*i +: 32] = uv;
          end else begin
            a = $signed(ua[15:0]); b = $signed(ub[15:0]);
            v = (t.cmd == CMD_HSUBW || t.cmd == CMD_HSUBSW) ? a - b : a + b;
            if (t.cmd == CMD_HADDSW || t.cmd == CMD_HSUBSW)
              r[16*i +: 16] = clamp_word(v);
            else
              r[16*i +: 16] = v[15:0];
          end
        end
      end
      CMD_MADDUBSW: begin
        // Unsigned bytes of the first source times signed bytes of the second.
        for (i = 0; i < 8; i++) begin
          a = int'(f[16*i +: 8]) * int'($signed(s[16*i +: 8]));
          b = int'(f[16*i+8 +: 8]) * int'($signed(s[16*i+8 +: 8]));
          r[16*i +: 16] = clamp_word(a + b);
        end
      end
      CMD_SIGNB, CMD_SIGNW, CMD_SIGND: begin
        n = (t.cmd == CMD_SIGNB) ? 1 : (t.cmd == CMD_SIGNW) ? 2 : 4;
        w = 8 * n;
        for (i = 0; i < 16 / n; i++) begin
          ub = 32'(s >> (w*i)) & ((n == 4) ? 32'hffff_ffff : ((32'h1 << w) - 1));
          ua = 32'(f >> (w*i));
          if (ub[w-1]) uv = 32'd0 - ua;
          else if (ub == 0) uv = 32'd0;
          else uv = ua;
          for (a = 0; a < w; a++) r[w*i + a] = uv[a];
        end
      end
      CMD_MULHRSW: begin
        for (i = 0; i < 8; i++) begin
          v = int'($signed(f[16*i +: 16])) * int'($signed(s[16*i +: 16]));
          uv = (32'(v) + 32'h4000) >> 15;
          r[16*i +: 16] = uv[15:0];
        end
      end
      CMD_ABSB, CMD_ABSW, CMD_ABSD: begin
        n = (t.cmd == CMD_ABSB) ? 1 : (t.cmd == CMD_ABSW) ? 2 : 4;
        w = 8 * n;
        for (i = 0; i < 16 / n; i++) begin
          ua = 32'(s >> (w*i));
          uv = ua[w-1] ? 32'd0 - ua : ua;
          for (a = 0; a < w; a++) r[w*i + a] = uv[a];
        end
      end
      default: begin
        cat = {f, s};
        for (i = 0; i < 16; i++)
          r[8*i +: 8] = (i + int'(t.shift_bytes) < 32) ?
                        cat[8*(i + t.shift_bytes) +: 8] : 8'h00;
      end
    endcase
    o.result_lo = r[63:0];
    o.result_hi = r[127:64];
    return o;
  endfunction

  // Send one transaction after a random gap and queue its expected lane.
  // Valid stays high between back-to-back transactions.
  task automatic send_lane(input in_t t);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lane_results_due.push_back(lane_op(t));
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Element patterns with a bias toward the extremes of bytes, words and dwords.
  function automatic logic [63:0] edgy64();
    logic [63:0] v;
    int k;
    v = rand64();
    for (k = 0; k < 8; k++)
      case ($urandom_range(0, 5))
        0: v[8*k +: 8] = 8'h80;
        1: v[8*k +: 8] = 8'h7f;
        2: v[8*k +: 8] = 8'hff;
        3: v[8*k +: 8] = 8'h00;
        default: ;
      endcase
    return v;
  endfunction

  function automatic in_t make_item(input logic [3:0] c, input logic [63:0] a0,
                                    input logic [63:0] a1, input logic [63:0] b0,
                                    input logic [63:0] b1, input logic [7:0] sh);
    in_t t;
    t.cmd = c; t.first_lo = a0; t.first_hi = a1;
    t.second_lo = b0; t.second_hi = b1; t.shift_bytes = sh;
    return t;
  endfunction

  // Output side: random stall per transaction, compare against the oldest expectation.
  initial begin
    int stall;
    out_t want;
    out_ready = 1'b0;
    mismatch_count = 0;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (lane_results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result lane %h_%h", out_data.result_hi, out_data.result_lo);
      end else begin
        want = lane_results_due.pop_front();
        if (out_data.result_lo !== want.result_lo || out_data.result_hi !== want.result_hi) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("lane mismatch: expected %h_%h got %h_%h", want.result_hi,
                     want.result_lo, out_data.result_hi, out_data.result_lo);
        end
      end
    end
  end

  task automatic test_shuffle();
    send_lane(make_item(CMD_SHUFB, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                        64'h8f0e0d0c0b0a0908, 64'h0001028083040506, 8'd0));
  endtask

  task automatic test_horizontal();
    logic [3:0] c;
    for (int k = 1; k <= 7; k++) begin
      c = k[3:0];
      if (c != CMD_MADDUBSW) begin
        send_lane(make_item(c, 64'h7fff7fff80008000, 64'h7fff800080007fff,
                            64'hffffffff80000000, 64'h7fffffff00000001, 8'd0));
      end
    end
    send_lane(make_item(CMD_MADDUBSW, 64'hffffffffffffffff, 64'h00ff80ff0000ffff,
                        64'h7f7f7f7f80808080, 64'h7f80807f7f807f80, 8'd0));
  endtask

  task automatic test_sign_abs();
    send_lane(make_item(CMD_SIGNB, 64'h80017f00ff807f01, 64'h0102030405060708,
                        64'hff00017f80ff0001, 64'h8000000000000080, 8'd0));
    send_lane(make_item(CMD_SIGNW, 64'h8000000100007fff, 64'h1234567880000001,
                        64'hffff000180000000, 64'h0000800000017fff, 8'd0));
    send_lane(make_item(CMD_SIGND, 64'h8000000000000001, 64'h7fffffff12345678,
                        64'h0000000080000000, 64'h00000001ffffffff, 8'd0));
    send_lane(make_item(CMD_ABSB, 64'h0, 64'h0, 64'h80ff7f0001fe8180, 64'h7f80ff00, 8'd0));
    send_lane(make_item(CMD_ABSW, 64'h0, 64'h0, 64'h8000ffff7fff0000, 64'h8001, 8'd0));
    send_lane(make_item(CMD_ABSD, 64'h0, 64'h0, 64'h80000000ffffffff, 64'h7fffffff00000000, 8'd0));
  endtask

  task automatic test_mulhrs();
    send_lane(make_item(CMD_MULHRSW, 64'h80007fff80000001, 64'h7fffffff40000000,
                        64'h80007fff7fffffff, 64'h800000014000ffff, 8'd0));
  endtask

  task automatic test_align();
    logic [7:0] counts[7] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd31, 8'd32, 8'd255};
    foreach (counts[k])
      send_lane(make_item(CMD_ALIGNR, 64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
                          64'h0706050403020100, 64'h0f0e0d0c0b0a0908, counts[k]));
  endtask

  task automatic test_random(input int count);
    logic [7:0] sh;
    for (int k = 0; k < count; k++) begin
      sh = ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 33));
      if ($urandom_range(0, 1))
        send_lane(make_item(4'($urandom()), rand64(), rand64(), rand64(), rand64(), sh));
      else
        send_lane(make_item(4'($urandom()), edgy64(), edgy64(), edgy64(), edgy64(), sh));
    end
  endtask

  // Cycle counter guarding against a hang anywhere in the run.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 200000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_shuffle();
    test_horizontal();
    test_sign_abs();
    test_mulhrs();
    test_align();
    test_random(400);
    in_valid <= 1'b0;
    while (lane_results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
